// ----- src/ffba_pkg.sv -----
`default_nettype none

package ffba_pkg;

    // Built depth of the cell map and width of a block id
    localparam int MEM_CELLS = 128;
    localparam int ID_BITS   = 8;

    // Widths of the fixed port fields
    localparam int FIELD_W = 8;
    localparam int CODE_W  = 2;

    // Cell address, and a count that can hold the depth itself
    localparam int ADDR_W = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;
    localparam int CNT_W  = $clog2(MEM_CELLS + 1);

    // Common widths for comparing ids and sizes against port fields
    localparam int CMP_W = (ID_BITS > FIELD_W) ? ID_BITS : FIELD_W;
    localparam int SZ_W  = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

    localparam logic [ID_BITS-1:0] ID_MAX    = {ID_BITS{1'b1}};
    localparam logic [FIELD_W-1:0] CFG_RESET = 8'd128;

    // Command codes
    localparam logic [CODE_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [CODE_W-1:0] OP_ERASE  = 2'd1;
    localparam logic [CODE_W-1:0] OP_DEFRAG = 2'd2;

    // Result status codes
    localparam logic [CODE_W-1:0] ST_GRANT   = 2'd0;
    localparam logic [CODE_W-1:0] ST_NULL    = 2'd1;
    localparam logic [CODE_W-1:0] ST_ILLEGAL = 2'd2;

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_EV   = 6'b000100,
        S_FILL = 6'b001000,
        S_CLR  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

endpackage

`default_nettype wire

// ----- src/ffba_ram.sv -----
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- src/first_fit_block_allocator.sv -----
`default_nettype none

// First-fit block allocator. Keeps an owner id for each of up to MEM_CELLS
// cells (cells_in_use of them are managed) and runs one command at a time:
// allocate claims the lowest run of block_size free cells under the next id,
// erase frees every cell of an id, defragment packs owned cells to the bottom.
// Every command walks the cell map through one RAM with one write port and a
// registered read port, reading each cell and then checking or writing it;
// allocate then fills the run it found, defragment clears the free cells
// above the packed ones, and a result is handed over from the done state.
// Rejected commands (zero or oversized size, ids used up, erase of id zero or
// with no managed cells) skip the walk. in_stall is high for the whole command.
// Allocate always returns one beat, erase returns a beat only when it is
// illegal, defragment and opcode 3 return none. The output register lets a new
// command start while the last beat waits on out_stall.

module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration
    input  wire logic               cfg_wr_en,
    input  wire logic [FIELD_W-1:0] cfg_wr_data,
    // command channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [CODE_W-1:0]  opcode,
    input  wire logic [FIELD_W-1:0] block_size,
    input  wire logic [FIELD_W-1:0] block_id,
    // result channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic      [CODE_W-1:0]  status,
    output logic      [FIELD_W-1:0] assigned_id
);

    // Control state
    state_t              state_reg, state_next;
    logic [FIELD_W-1:0]  cells_in_use_reg;
    logic [ID_BITS-1:0]  next_id_reg, next_id_next;
    logic                hit_reg, hit_next;
    logic                out_valid_reg, out_valid_next;
    logic [MEM_CELLS-1:0] vld_reg;
    logic                vld_q_reg;

    // Command payload and working registers
    logic [CODE_W-1:0]   op_reg, op_next;
    logic [CNT_W-1:0]    size_reg, size_next;
    logic [CMP_W-1:0]    id_reg, id_next;
    logic [CNT_W-1:0]    m_reg, m_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    run_reg, run_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic [CODE_W-1:0]   res_status_reg, res_status_next;
    logic [FIELD_W-1:0]  res_id_reg, res_id_next;
    logic [CODE_W-1:0]   status_reg, status_next;
    logic [FIELD_W-1:0]  assigned_id_reg, assigned_id_next;

    // RAM port signals
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ID_BITS-1:0]  ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ID_BITS-1:0]  ram_rdata;

    // Datapath helpers
    logic [SZ_W-1:0]     cfg_ext;
    logic [CNT_W-1:0]    m_now;
    logic [SZ_W-1:0]     size_ext;
    logic [ID_BITS-1:0]  owner;
    logic [CNT_W-1:0]    idx_inc;
    logic [CNT_W-1:0]    run_inc;
    logic [CNT_W-1:0]    ptr_inc;
    logic                is_last;
    logic                id_match;
    logic [ID_BITS-1:0]  new_id;
    logic [CMP_W-1:0]    new_id_ext;
    logic                out_free;

    ffba_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (MEM_CELLS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Managed cell count, saturated at the built depth
    assign cfg_ext  = SZ_W'(cells_in_use_reg);
    assign m_now    = (cfg_ext > SZ_W'(MEM_CELLS)) ? CNT_W'(MEM_CELLS) : cfg_ext[CNT_W-1:0];
    assign size_ext = SZ_W'(block_size);

    // Owner of the cell just read; a never-written cell is free
    assign owner      = vld_q_reg ? ram_rdata : '0;
    assign idx_inc    = idx_reg + CNT_W'(1);
    assign run_inc    = run_reg + CNT_W'(1);
    assign ptr_inc    = ptr_reg + CNT_W'(1);
    assign is_last    = (idx_inc == m_reg);
    assign id_match   = (CMP_W'(owner) == id_reg);
    assign new_id     = next_id_reg + ID_BITS'(1);
    assign new_id_ext = CMP_W'(new_id);
    assign out_free   = !out_valid_reg || !out_stall;

    assign ram_raddr = idx_reg[ADDR_W-1:0];

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        next_id_next    = next_id_reg;
        hit_next        = hit_reg;
        op_next         = op_reg;
        size_next       = size_reg;
        id_next         = id_reg;
        m_next          = m_reg;
        idx_next        = idx_reg;
        run_next        = run_reg;
        ptr_next        = ptr_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        ram_we          = 1'b0;
        ram_waddr       = ptr_reg[ADDR_W-1:0];
        ram_wdata       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = opcode;
                    size_next   = size_ext[CNT_W-1:0];
                    id_next     = CMP_W'(block_id);
                    m_next      = m_now;
                    idx_next    = '0;
                    run_next    = '0;
                    ptr_next    = '0;
                    hit_next    = 1'b0;
                    res_id_next = '0;
                    unique case (opcode)
                        OP_ALLOC:
                        begin
                            if (block_size == '0 || size_ext > SZ_W'(m_now)
                                || next_id_reg == ID_MAX)
                            begin
                                res_status_next = ST_NULL;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        OP_ERASE:
                        begin
                            if (block_id == '0 || m_now == '0)
                            begin
                                res_status_next = ST_ILLEGAL;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        OP_DEFRAG:
                        begin
                            if (m_now != '0)
                            begin
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                state_next = S_EV;
            end

            S_EV:
            begin
                state_next = S_RD;
                idx_next   = idx_inc;
                unique case (op_reg)
                    OP_ALLOC:
                    begin
                        if (owner == '0)
                        begin
                            run_next = run_inc;
                        end
                        else
                        begin
                            run_next = '0;
                        end
                        if (owner == '0 && run_inc == size_reg)
                        begin
                            // run found: fill from its first cell up to this one
                            ptr_next   = idx_inc - size_reg;
                            idx_next   = idx_reg;
                            state_next = S_FILL;
                        end
                        else if (is_last)
                        begin
                            res_status_next = ST_NULL;
                            state_next      = S_DONE;
                        end
                    end
                    OP_ERASE:
                    begin
                        if (id_match)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = idx_reg[ADDR_W-1:0];
                            hit_next  = 1'b1;
                        end
                        if (is_last)
                        begin
                            if (hit_reg || id_match)
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                res_status_next = ST_ILLEGAL;
                                state_next      = S_DONE;
                            end
                        end
                    end
                    default:
                    begin
                        // compaction: copy owned cell down to the write pointer
                        if (owner != '0)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = owner;
                            ptr_next  = ptr_inc;
                        end
                        if (is_last)
                        begin
                            if (((owner != '0) ? ptr_inc : ptr_reg) != m_reg)
                            begin
                                state_next = S_CLR;
                            end
                            else
                            begin
                                state_next = S_IDLE;
                            end
                        end
                    end
                endcase
            end

            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_wdata = new_id;
                ptr_next  = ptr_inc;
                if (ptr_reg == idx_reg)
                begin
                    next_id_next    = new_id;
                    res_status_next = ST_GRANT;
                    res_id_next     = new_id_ext[FIELD_W-1:0];
                    state_next      = S_DONE;
                end
            end

            S_CLR:
            begin
                // free the cells above the packed ones
                ram_we   = 1'b1;
                ptr_next = ptr_inc;
                if (ptr_inc == m_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next   = out_valid_reg && out_stall;
        status_next      = status_reg;
        assigned_id_next = assigned_id_reg;
        if (state_reg == S_DONE && out_free)
        begin
            out_valid_next   = 1'b1;
            status_next      = res_status_reg;
            assigned_id_next = res_id_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cells_in_use_reg <= CFG_RESET;
            next_id_reg      <= '0;
            hit_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
            vld_reg          <= '0;
            vld_q_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_id_reg   <= next_id_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            vld_q_reg     <= vld_reg[ram_raddr];
            if (cfg_wr_en)
            begin
                cells_in_use_reg <= cfg_wr_data;
            end
            if (ram_we)
            begin
                vld_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        size_reg        <= size_next;
        id_reg          <= id_next;
        m_reg           <= m_next;
        idx_reg         <= idx_next;
        run_reg         <= run_next;
        ptr_reg         <= ptr_next;
        res_status_reg  <= res_status_next;
        res_id_reg      <= res_id_next;
        status_reg      <= status_next;
        assigned_id_reg <= assigned_id_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign assigned_id = assigned_id_reg;

endmodule

`default_nettype wire

// ----- src/ffba_checker.sv -----
`default_nettype none

module ffba_checker
    import ffba_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               cfg_wr_en,
    input wire logic [FIELD_W-1:0] cfg_wr_data,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic [CODE_W-1:0]  opcode,
    input wire logic [FIELD_W-1:0] block_size,
    input wire logic [FIELD_W-1:0] block_id,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [CODE_W-1:0]  status,
    input wire logic [FIELD_W-1:0] assigned_id
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(assigned_id))
        else $error("result beat changed while stalled");

    // An accepted allocate keeps the command side busy
    a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode == OP_ALLOC |=> in_stall)
        else $error("allocate accepted but block not busy");

    // Failures and illegal erases carry a zero id; the code is never 3
    a_status_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_GRANT)
                      || ((status == ST_NULL || status == ST_ILLEGAL) && assigned_id == '0))
        else $error("bad status or nonzero id on a failed beat");

    // A new result beat comes only out of a busy command
    a_beat_from_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result beat without a command in progress");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);

`default_nettype wire
